FILE: hw/rtl/ptcb_pkg.sv
// Shared constants, types and register codes of the point transform crop-box filter.
package ptcb_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int COEF_WIDTH      = 16;
   localparam int BOUND_WIDTH     = 32;
   localparam int INTENSITY_WIDTH = 16;
   localparam int RING_WIDTH      = 7;
   localparam int TIME_WIDTH      = 32;

   localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
   localparam int SHR_WIDTH  = PROD_WIDTH - COEF_FRAC_BITS;
   localparam int SUM_BASE   = (SHR_WIDTH > BOUND_WIDTH) ?
                               ((SHR_WIDTH > COORD_WIDTH) ? SHR_WIDTH : COORD_WIDTH) :
                               ((BOUND_WIDTH > COORD_WIDTH) ? BOUND_WIDTH : COORD_WIDTH);
   localparam int SUM_WIDTH  = SUM_BASE + 2;
   localparam int CMP_WIDTH  = (COORD_WIDTH > BOUND_WIDTH) ? COORD_WIDTH : BOUND_WIDTH;

   localparam int META_WIDTH  = INTENSITY_WIDTH + RING_WIDTH + TIME_WIDTH;
   localparam int PAY_WIDTH   = 3 * COORD_WIDTH + META_WIDTH;
   localparam int TDATA_WIDTH = ((PAY_WIDTH + 7) / 8) * 8;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int ROT_WIDTH       = 3 * COEF_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROT_ROW0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROT_ROW1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROT_ROW2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TRANS_XY = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TRANS_Z  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_X    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_Y    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Z_FLOOR  = 3'd7;

   localparam logic [ROT_WIDTH-1:0]      RST_ROT_ROW0 = 48'h0000_0000_4000;
   localparam logic [ROT_WIDTH-1:0]      RST_ROT_ROW1 = 48'h0000_4000_0000;
   localparam logic [ROT_WIDTH-1:0]      RST_ROT_ROW2 = 48'h4000_0000_0000;
   localparam logic [2*BOUND_WIDTH-1:0]  RST_TRANS_XY = 64'h0;
   localparam logic [BOUND_WIDTH-1:0]    RST_TRANS_Z  = 32'h0;
   localparam logic [2*BOUND_WIDTH-1:0]  RST_BOX_X    = 64'h0014_0000_FFF3_0000;
   localparam logic [2*BOUND_WIDTH-1:0]  RST_BOX_Y    = 64'h001E_0000_FFE7_0000;
   localparam logic [BOUND_WIDTH-1:0]    RST_Z_FLOOR  = 32'h0000_3333;

   typedef logic [2:0][COORD_WIDTH-1:0]            pos_type;
   typedef logic [2:0][2:0][SHR_WIDTH-1:0]         shr_type;
   typedef logic [2:0][SUM_WIDTH-1:0]              sum_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]      time_offset;
      logic [RING_WIDTH-1:0]      ring;
      logic [INTENSITY_WIDTH-1:0] intensity;
   } meta_type;

   typedef struct packed {
      logic [2:0][2:0][COEF_WIDTH-1:0] rot;
      logic [2:0][BOUND_WIDTH-1:0]     trans;
      logic [BOUND_WIDTH-1:0]          x_min;
      logic [BOUND_WIDTH-1:0]          x_max;
      logic [BOUND_WIDTH-1:0]          y_min;
      logic [BOUND_WIDTH-1:0]          y_max;
      logic [BOUND_WIDTH-1:0]          z_floor;
   } cfg_type;

endpackage

FILE: hw/rtl/ptcb_csr.sv
// Configuration registers of the point transform crop-box filter.
module ptcb_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [ptcb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ptcb_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output ptcb_pkg::cfg_type                     cfg
);
   import ptcb_pkg::*;

   logic [ROT_WIDTH-1:0]     rot0_ff, rot1_ff, rot2_ff;
   logic [2*BOUND_WIDTH-1:0] trans_xy_ff, box_x_ff, box_y_ff;
   logic [BOUND_WIDTH-1:0]   trans_z_ff, z_floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff     <= RST_ROT_ROW0;
         rot1_ff     <= RST_ROT_ROW1;
         rot2_ff     <= RST_ROT_ROW2;
         trans_xy_ff <= RST_TRANS_XY;
         trans_z_ff  <= RST_TRANS_Z;
         box_x_ff    <= RST_BOX_X;
         box_y_ff    <= RST_BOX_Y;
         z_floor_ff  <= RST_Z_FLOOR;
      end else if (csr_wen) begin
         case (csr_index)
            REG_ROT_ROW0: rot0_ff     <= csr_wdata[ROT_WIDTH-1:0];
            REG_ROT_ROW1: rot1_ff     <= csr_wdata[ROT_WIDTH-1:0];
            REG_ROT_ROW2: rot2_ff     <= csr_wdata[ROT_WIDTH-1:0];
            REG_TRANS_XY: trans_xy_ff <= csr_wdata[2*BOUND_WIDTH-1:0];
            REG_TRANS_Z:  trans_z_ff  <= csr_wdata[BOUND_WIDTH-1:0];
            REG_BOX_X:    box_x_ff    <= csr_wdata[2*BOUND_WIDTH-1:0];
            REG_BOX_Y:    box_y_ff    <= csr_wdata[2*BOUND_WIDTH-1:0];
            REG_Z_FLOOR:  z_floor_ff  <= csr_wdata[BOUND_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.rot[0]   = rot0_ff;
      cfg.rot[1]   = rot1_ff;
      cfg.rot[2]   = rot2_ff;
      cfg.trans[0] = trans_xy_ff[BOUND_WIDTH-1:0];
      cfg.trans[1] = trans_xy_ff[2*BOUND_WIDTH-1:BOUND_WIDTH];
      cfg.trans[2] = trans_z_ff;
      cfg.x_min    = box_x_ff[BOUND_WIDTH-1:0];
      cfg.x_max    = box_x_ff[2*BOUND_WIDTH-1:BOUND_WIDTH];
      cfg.y_min    = box_y_ff[BOUND_WIDTH-1:0];
      cfg.y_max    = box_y_ff[2*BOUND_WIDTH-1:BOUND_WIDTH];
      cfg.z_floor  = z_floor_ff;
   end

endmodule

FILE: hw/rtl/ptcb_mult.sv
// Stage one: nine coefficient products, floor-shifted to the coordinate scale.
module ptcb_mult (
   input  logic              clock,
   input  logic              en,
   input  ptcb_pkg::pos_type pos,
   input  ptcb_pkg::cfg_type cfg,
   output ptcb_pkg::shr_type shr_ff
);
   import ptcb_pkg::*;

   logic signed [PROD_WIDTH-1:0] prod [3][3];
   shr_type                      shr_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod[r][c]   = PROD_WIDTH'(signed'(cfg.rot[r][c])) *
                           PROD_WIDTH'(signed'(pos[c]));
            shr_in[r][c] = SHR_WIDTH'(prod[r][c] >>> COEF_FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         shr_ff <= shr_in;
      end
   end

endmodule

FILE: hw/rtl/ptcb_sum.sv
// Stage two: row sums of the shifted products plus translation.
module ptcb_sum (
   input  logic              clock,
   input  logic              en,
   input  ptcb_pkg::shr_type shr,
   input  ptcb_pkg::cfg_type cfg,
   output ptcb_pkg::sum_type sum_ff
);
   import ptcb_pkg::*;

   sum_type sum_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SUM_WIDTH'(signed'(shr[r][0])) + SUM_WIDTH'(signed'(shr[r][1]))
                   + SUM_WIDTH'(signed'(shr[r][2])) + SUM_WIDTH'(signed'(cfg.trans[r]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

endmodule

FILE: hw/rtl/ptcb_clip.sv
// Stage three: saturation to the coordinate width and the crop-box test.
module ptcb_clip (
   input  logic              clock,
   input  logic              en,
   input  ptcb_pkg::sum_type sum,
   input  ptcb_pkg::cfg_type cfg,
   output ptcb_pkg::pos_type pos_ff,
   output logic              inside_ff
);
   import ptcb_pkg::*;

   localparam int HEAD = SUM_WIDTH - COORD_WIDTH + 1;

   pos_type                     pos_in;
   logic signed [CMP_WIDTH-1:0] cmp [3];
   logic                        inside_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (sum[r][SUM_WIDTH-1:COORD_WIDTH-1] == {HEAD{1'b0}} ||
             sum[r][SUM_WIDTH-1:COORD_WIDTH-1] == {HEAD{1'b1}}) begin
            pos_in[r] = sum[r][COORD_WIDTH-1:0];
         end else if (sum[r][SUM_WIDTH-1]) begin
            pos_in[r] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            pos_in[r] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end
         cmp[r] = CMP_WIDTH'(signed'(pos_in[r]));
      end
      inside_in = (cmp[0] > CMP_WIDTH'(signed'(cfg.x_min))) &&
                  (cmp[0] < CMP_WIDTH'(signed'(cfg.x_max))) &&
                  (cmp[1] > CMP_WIDTH'(signed'(cfg.y_min))) &&
                  (cmp[1] < CMP_WIDTH'(signed'(cfg.y_max))) &&
                  (cmp[2] > CMP_WIDTH'(signed'(cfg.z_floor)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff    <= pos_in;
         inside_ff <= inside_in;
      end
   end

endmodule

FILE: hw/rtl/point_transform_crop_box_filter_top.sv
// Top level of the point transform crop-box filter.
// One point per cycle is taken while the output stage is free or being emptied; an accepted
// point passes four register stages (multiply, row sum, saturate and box test, output
// register) on its way to the result register. Points that fall inside the crop box leave
// no result and free their slot at once, so they never hold up the stream.
// Configuration writes take effect on the next cycle and are expected while the pipeline is
// empty.
module point_transform_crop_box_filter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pos_x, pos_y, pos_z, intensity, ring, time_offset, zero fill
   input  logic [ptcb_pkg::TDATA_WIDTH-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_x, out_y, out_z, out_intensity, out_ring, out_time, zero fill
   output logic [ptcb_pkg::TDATA_WIDTH-1:0]     rsp_tdata,
   input  logic                                 csr_wen,
   input  logic [ptcb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ptcb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import ptcb_pkg::*;

   cfg_type  cfg;
   pos_type  req_pos;
   meta_type req_meta;
   shr_type  shr;
   sum_type  sum;
   pos_type  clip_pos;
   logic     clip_inside;

   logic     v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   meta_type meta1_ff, meta2_ff, meta3_ff;
   logic [PAY_WIDTH-1:0] rsp_data_ff;
   logic     go_o, go3, go2, go1;

   assign req_pos  = req_tdata[3*COORD_WIDTH-1:0];
   assign req_meta = req_tdata[PAY_WIDTH-1:3*COORD_WIDTH];

   // stages move when the next one is empty or moving; dropped points always move
   assign go_o = !rsp_valid_ff || rsp_tready;
   assign go3  = !v3_ff || clip_inside || go_o;
   assign go2  = !v2_ff || go3;
   assign go1  = !v1_ff || go2;
   assign req_tready = go1;

   ptcb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptcb_mult u_mult (
      .clock  (clock),
      .en     (go1),
      .pos    (req_pos),
      .cfg    (cfg),
      .shr_ff (shr)
   );

   ptcb_sum u_sum (
      .clock  (clock),
      .en     (go2),
      .shr    (shr),
      .cfg    (cfg),
      .sum_ff (sum)
   );

   ptcb_clip u_clip (
      .clock     (clock),
      .en        (go3),
      .sum       (sum),
      .cfg       (cfg),
      .pos_ff    (clip_pos),
      .inside_ff (clip_inside)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go1) v1_ff <= req_tvalid;
         if (go2) v2_ff <= v1_ff;
         if (go3) v3_ff <= v2_ff;
         if (go_o) rsp_valid_ff <= v3_ff && !clip_inside;
      end
   end

   always_ff @(posedge clock) begin
      if (go1) meta1_ff <= req_meta;
      if (go2) meta2_ff <= meta1_ff;
      if (go3) meta3_ff <= meta2_ff;
      if (go_o) rsp_data_ff <= {meta3_ff, clip_pos};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(rsp_data_ff);

endmodule

FILE: hw/rtl/ptcb_checker.sv
// Port-level checks of the point transform crop-box filter, bound to its top level.
module ptcb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ptcb_pkg::TDATA_WIDTH-1:0] rsp_tdata
);
   import ptcb_pkg::*;

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a free or draining output stage lets the pipeline take a point
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled with output free");

   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

endmodule

bind point_transform_crop_box_filter_top ptcb_checker u_ptcb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: verif/tb_point_transform_crop_box_filter_top.sv
// Self-checking testbench of the point transform crop-box filter with a local predictor.
`timescale 1ns / 100ps

module tb_point_transform_crop_box_filter_top;
   import ptcb_pkg::*;

   typedef struct packed {
      logic [31:0] time_offset;
      logic [6:0]  ring;
      logic [15:0] intensity;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } point_type;

   localparam int POINT_BITS    = $bits(point_type);
   localparam int ONE_M         = 65536;
   localparam int NEAR_SPAN     = 48 * ONE_M;
   localparam int PIPE_LATENCY  = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 3000;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_POINTS  = 250;
   localparam int RSP_FREE      = 0;
   localparam int RSP_RANDOM    = 1;
   localparam int RSP_PATTERN   = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] ROT_REGS [3] = '{REG_ROT_ROW0, REG_ROT_ROW1,
                                                           REG_ROT_ROW2};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [TDATA_WIDTH-1:0]     req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [TDATA_WIDTH-1:0]     rsp_tdata;
   logic                       csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // local copy of the register file
   logic [47:0] rot_rows [3];
   logic [63:0] trans_xy_q, box_x_q, box_y_q;
   logic [31:0] trans_z_q, z_floor_q;

   point_type   expected_points [$];
   int          error_count = 0;
   int          accepted_points = 0;
   int          checked_points = 0;
   int          dropped_points = 0;
   int          rsp_mode = RSP_FREE;
   int          stall_phase = 0;
   int          burst_left = 0;
   int unsigned quiet_cycles = 0;
   bit          bursty = 1'b0;
   logic        holding = 1'b0;
   event        hold_kick;

   point_transform_crop_box_filter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] rotate_row(input logic [47:0] row, input point_type p,
                                              input logic [31:0] offset);
      logic signed [63:0] acc;
      logic signed [47:0] prod;
      logic signed [15:0] k;
      logic signed [31:0] v;
      acc = 64'(signed'(offset));
      for (int c = 0; c < 3; c++) begin
         k = row[16*c +: 16];
         v = (c == 0) ? p.x : (c == 1) ? p.y : p.z;
         prod = 48'(k) * 48'(v);
         acc = acc + 64'(prod >>> COEF_FRAC_BITS);
      end
      if (acc > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (acc < -64'sh8000_0000) return 32'h8000_0000;
      return acc[31:0];
   endfunction

   // returns 1 when the transformed point leaves the block
   function automatic bit transform_point(input point_type p, output point_type r);
      logic signed [31:0] nx, ny, nz;
      nx = rotate_row(rot_rows[0], p, trans_xy_q[31:0]);
      ny = rotate_row(rot_rows[1], p, trans_xy_q[63:32]);
      nz = rotate_row(rot_rows[2], p, trans_z_q);
      r = p;
      r.x = nx;
      r.y = ny;
      r.z = nz;
      return !(nx > signed'(box_x_q[31:0]) && nx < signed'(box_x_q[63:32]) &&
               ny > signed'(box_y_q[31:0]) && ny < signed'(box_y_q[63:32]) &&
               nz > signed'(z_floor_q));
   endfunction

   function automatic point_type make_point(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z, input logic [15:0] inten,
                                            input logic [6:0] ring, input logic [31:0] t);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      p.intensity = inten;
      p.ring = ring;
      p.time_offset = t;
      return p;
   endfunction

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
      return $urandom;
   endfunction

   function automatic point_type rand_point();
      return make_point(rand_coord(), rand_coord(), rand_coord(), 16'($urandom),
                        7'($urandom), $urandom);
   endfunction

   function automatic logic [15:0] rand_coef(input bit diag);
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return diag ? 16'h4000 : 16'h0000;
         2: return diag ? 16'hC000 : 16'h0000;
         default: return diag ? 16'(16'h4000 + $urandom_range(0, 2047) - 1024) :
                                16'($urandom_range(0, 2047) - 1024);
      endcase
   endfunction

   function automatic logic [31:0] rand_offset();
      if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 10 * ONE_M)) - 5 * ONE_M;
      return $urandom;
   endfunction

   function automatic logic [63:0] rand_bounds();
      int lo_b, hi_b;
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: begin
            lo_b = int'($urandom_range(0, 60 * ONE_M)) - 30 * ONE_M;
            hi_b = lo_b - int'($urandom_range(0, 8 * ONE_M));
         end
         default: begin
            lo_b = int'($urandom_range(0, 60 * ONE_M)) - 40 * ONE_M;
            hi_b = lo_b + int'($urandom_range(ONE_M, 60 * ONE_M));
         end
      endcase
      return {hi_b, lo_b};
   endfunction

   task automatic report_fault(input string msg);
      if (error_count < 40) $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_fault($sformatf("transaction %0d %s got %h expected %h",
                                checked_points, name, got, want));
   endtask

   task automatic check_result(input logic [TDATA_WIDTH-1:0] data);
      point_type got, want;
      got = data[POINT_BITS-1:0];
      if (expected_points.size() == 0) begin
         report_fault($sformatf("result with nothing pending: %h", data));
         return;
      end
      want = expected_points.pop_front();
      compare_field("out_x", got.x, want.x);
      compare_field("out_y", got.y, want.y);
      compare_field("out_z", got.z, want.z);
      compare_field("out_intensity", 32'(got.intensity), 32'(want.intensity));
      compare_field("out_ring", 32'(got.ring), 32'(want.ring));
      compare_field("out_time", got.time_offset, want.time_offset);
      checked_points++;
   endtask

   task automatic load_reset_model();
      rot_rows[0] = RST_ROT_ROW0;
      rot_rows[1] = RST_ROT_ROW1;
      rot_rows[2] = RST_ROT_ROW2;
      trans_xy_q = RST_TRANS_XY;
      trans_z_q = RST_TRANS_Z;
      box_x_q = RST_BOX_X;
      box_y_q = RST_BOX_Y;
      z_floor_q = RST_Z_FLOOR;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [63:0] data);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (index)
         REG_ROT_ROW0: rot_rows[0] = data[47:0];
         REG_ROT_ROW1: rot_rows[1] = data[47:0];
         REG_ROT_ROW2: rot_rows[2] = data[47:0];
         REG_TRANS_XY: trans_xy_q = data;
         REG_TRANS_Z:  trans_z_q = data[31:0];
         REG_BOX_X:    box_x_q = data;
         REG_BOX_Y:    box_y_q = data;
         REG_Z_FLOOR:  z_floor_q = data[31:0];
         default: ;
      endcase
   endtask

   task automatic write_defaults();
      write_reg(REG_ROT_ROW0, 64'(RST_ROT_ROW0));
      write_reg(REG_ROT_ROW1, 64'(RST_ROT_ROW1));
      write_reg(REG_ROT_ROW2, 64'(RST_ROT_ROW2));
      write_reg(REG_TRANS_XY, RST_TRANS_XY);
      write_reg(REG_TRANS_Z, 64'(RST_TRANS_Z));
      write_reg(REG_BOX_X, RST_BOX_X);
      write_reg(REG_BOX_Y, RST_BOX_Y);
      write_reg(REG_Z_FLOOR, 64'(RST_Z_FLOOR));
   endtask

   // drop valid, let all results arrive and the pipeline empty of dropped points
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_point(input point_type p);
      point_type r;
      req_tdata <= TDATA_WIDTH'(p);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      accepted_points++;
      if (transform_point(p, r)) expected_points.insert(expected_points.size(), r);
      else dropped_points++;
   endtask

   task automatic offer_point(input point_type p);
      if (bursty) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      send_point(p);
   endtask

   task automatic test_reset_defaults();
      rsp_mode <= RSP_FREE;
      bursty = 1'b0;
      send_point(make_point(0, 0, ONE_M, 16'h0000, 7'h00, 32'h0000_0000));
      send_point(make_point(-13 * ONE_M, 0, ONE_M, 16'hFFFF, 7'h7F, 32'hFFFF_FFFF));
      send_point(make_point(-13 * ONE_M + 1, 0, ONE_M, 16'h1234, 7'h15, 32'h8000_0001));
      send_point(make_point(20 * ONE_M, 0, ONE_M, 16'h8001, 7'h2A, 32'h7FFF_FFFE));
      send_point(make_point(20 * ONE_M - 1, 0, ONE_M, 16'h5A5A, 7'h55, 32'hA5A5_A5A5));
      send_point(make_point(0, -25 * ONE_M, ONE_M, 16'h0001, 7'h01, 32'h0000_0001));
      send_point(make_point(0, 30 * ONE_M - 1, ONE_M, 16'hA5A5, 7'h2A, 32'h5A5A_5A5A));
      send_point(make_point(0, 0, 13107, 16'h00FF, 7'h0F, 32'h0F0F_0F0F));
      send_point(make_point(0, 0, 13108, 16'hFF00, 7'h70, 32'hF0F0_F0F0));
      send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            16'hFFFF, 7'h7F, 32'hFFFF_FFFF));
      send_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            16'h0000, 7'h00, 32'h0000_0000));
   endtask

   task automatic test_saturation();
      settle();
      write_reg(REG_ROT_ROW0, 64'hFFFF_7FFF_7FFF_7FFF);
      write_reg(REG_ROT_ROW1, 64'h0000_8000_8000_8000);
      write_reg(REG_ROT_ROW2, 64'hABCD_8000_0000_7FFF);
      write_reg(REG_TRANS_XY, 64'h8000_0000_7FFF_FFFF);
      write_reg(REG_TRANS_Z, 64'hFFFF_FFFF_8000_0000);
      send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1111, 7'h11, 1));
      send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h2222, 7'h22, 2));
      send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'h3333, 7'h33, 3));
      send_point(make_point(0, 0, 0, 16'h4444, 7'h44, 4));
      // flooring of negative products
      settle();
      write_reg(REG_ROT_ROW0, 64'h0000_0001_0001_0001);
      write_reg(REG_ROT_ROW1, 64'h0000_FFFF_FFFF_FFFF);
      write_reg(REG_ROT_ROW2, 64'h0000_0000_0000_4001);
      write_reg(REG_TRANS_XY, 64'h0);
      write_reg(REG_TRANS_Z, 64'h0);
      send_point(make_point(-1, -1, -1, 16'h5555, 7'h55, 5));
      send_point(make_point(1, 1, 1, 16'h6666, 7'h66, 6));
      send_point(make_point(-16385, 16383, -3 * ONE_M, 16'h7777, 7'h77, 7));
   endtask

   task automatic test_empty_box();
      settle();
      write_defaults();
      write_reg(REG_BOX_X, {ONE_M, ONE_M});
      send_point(make_point(ONE_M, 0, ONE_M, 16'h0101, 7'h01, 8));
      send_point(make_point(0, 0, ONE_M, 16'h0202, 7'h02, 9));
      settle();
      write_reg(REG_BOX_X, {-5 * ONE_M, 5 * ONE_M});
      send_point(make_point(0, 0, ONE_M, 16'h0303, 7'h03, 10));
      settle();
      write_reg(REG_BOX_X, 64'h7FFF_FFFF_8000_0000);
      write_reg(REG_BOX_Y, 64'h7FFF_FFFF_8000_0000);
      write_reg(REG_Z_FLOOR, 64'h1234_5678_8000_0000);
      send_point(make_point(0, 0, 0, 16'h0404, 7'h04, 11));
      send_point(make_point(32'h7FFF_FFFF, 0, 0, 16'h0505, 7'h05, 12));
      send_point(make_point(0, 32'h8000_0000, 0, 16'h0606, 7'h06, 13));
      send_point(make_point(0, 0, 32'h8000_0000, 16'h0707, 7'h07, 14));
      settle();
      write_reg(REG_Z_FLOOR, 64'h7FFF_FFFF);
      send_point(make_point(0, 0, 32'h7FFF_FFFF, 16'h0808, 7'h08, 15));
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         for (int r = 0; r < 3; r++)
            write_reg(ROT_REGS[r], {16'($urandom), rand_coef(r == 2), rand_coef(r == 1),
                                    rand_coef(r == 0)});
         write_reg(REG_TRANS_XY, {rand_offset(), rand_offset()});
         write_reg(REG_TRANS_Z, {$urandom, rand_offset()});
         write_reg(REG_BOX_X, rand_bounds());
         write_reg(REG_BOX_Y, rand_bounds());
         write_reg(REG_Z_FLOOR, {$urandom, ($urandom_range(0, 4) == 0) ? 32'($urandom) :
                                 32'(int'($urandom_range(0, 6 * ONE_M)) - 3 * ONE_M)});
         rsp_mode <= int'($urandom_range(RSP_FREE, RSP_PATTERN));
         bursty = ($urandom_range(0, 3) != 0);
         repeat (PHASE_POINTS) offer_point(rand_point());
      end
   endtask

   task automatic test_output_stall();
      settle();
      write_defaults();
      rsp_mode <= RSP_FREE;
      bursty = 1'b0;
      -> hold_kick;
      repeat (200) send_point(rand_point());
   endtask

   initial begin
      load_reset_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_saturation();
      test_empty_box();
      test_random_settings();
      test_output_stall();
      settle();
      $display("%0d points sent, %0d results checked, %0d dropped inside the box",
               accepted_points, checked_points, dropped_points);
      $display("reset values, saturation, flooring, empty and inverted boxes, %0d random %s",
               RANDOM_PHASES, "register settings and a long output stall");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // long receiver hold-off
   initial forever begin
      @(hold_kick);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         stall_phase <= (stall_phase == 8) ? 0 : stall_phase + 1;
         if (holding) begin
            rsp_tready <= 1'b0;
         end else begin
            case (rsp_mode)
               RSP_RANDOM:  rsp_tready <= ($urandom_range(0, 99) >= 35);
               RSP_PATTERN: rsp_tready <= (stall_phase < 6);
               default: rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
